// File: hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 8-bit load/ALU core.
// No dependencies; used by cpu_8bit_load_alu_core.
package cpu8_pkg;

   localparam int ADDR_BITS_DEF = 16;

   // request kinds
   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_EXEC  = 2'd2;

   // register file slots
   localparam logic [2:0] REG_B = 3'd0;
   localparam logic [2:0] REG_C = 3'd1;
   localparam logic [2:0] REG_D = 3'd2;
   localparam logic [2:0] REG_E = 3'd3;
   localparam logic [2:0] REG_H = 3'd4;
   localparam logic [2:0] REG_L = 3'd5;
   localparam logic [2:0] REG_M = 3'd6;   // (HL) operand code
   localparam logic [2:0] REG_A = 3'd7;

   // ALU groups of opcodes 0x80..0xBF
   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_AND = 3'd4;
   localparam logic [2:0] ALU_XOR = 3'd5;
   localparam logic [2:0] ALU_OR  = 3'd6;
   localparam logic [2:0] ALU_CP  = 3'd7;

   // opcodes decoded one by one
   localparam logic [7:0] OP_HALT  = 8'h76;
   localparam logic [7:0] OP_LDABC = 8'h0A;
   localparam logic [7:0] OP_LDADE = 8'h1A;
   localparam logic [7:0] OP_LDBCA = 8'h02;
   localparam logic [7:0] OP_LDDEA = 8'h12;
   localparam logic [7:0] OP_LDAC  = 8'hF2;
   localparam logic [7:0] OP_LDCA  = 8'hE2;
   localparam logic [7:0] OP_LDHAN = 8'hF0;
   localparam logic [7:0] OP_LDHNA = 8'hE0;
   localparam logic [7:0] OP_LDANN = 8'hFA;
   localparam logic [7:0] OP_LDNNA = 8'hEA;
   localparam logic [7:0] OP_LDAHI = 8'h2A;
   localparam logic [7:0] OP_LDAHD = 8'h3A;
   localparam logic [7:0] OP_LDHIA = 8'h22;
   localparam logic [7:0] OP_LDHDA = 8'h32;
   localparam logic [7:0] OP_RLCA  = 8'h07;
   localparam logic [7:0] OP_RLA   = 8'h17;
   localparam logic [7:0] OP_RRCA  = 8'h0F;
   localparam logic [7:0] OP_RRA   = 8'h1F;

   localparam logic [7:0] HIGH_PAGE  = 8'hFF;
   localparam logic [3:0] FLAGS_INIT = 4'hB;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  acc_out;
      logic [15:0] pair_bc;
      logic [15:0] pair_de;
      logic [15:0] pair_hl;
      logic [15:0] pc_out;
      logic [3:0]  flags_out;
   } rsp_item_type;

endpackage

// File: hw/rtl/cpu_8bit_load_alu_core.sv
`timescale 1ns / 1ps
// 8-bit load/ALU core: byte memory, register file, program counter and flags.
// Depends on cpu8_pkg.
//
// After reset the core sweeps the byte memory to zero, one byte a cycle, with
// busy high. An item is taken when start is high and busy is low; its result
// appears on rsp_item for one cycle with rsp_strobe high and cannot be held
// off. Everything goes through one single-port memory with a registered read,
// so a write goes straight to its result, a read waits a data state, and an
// executed instruction steps through opcode fetch, up to two immediate bytes,
// one data access, then the result cycle. busy stays high until the result
// cycle has passed.
module cpu_8bit_load_alu_core
   import cpu8_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b0000_0001,
      S_IDLE  = 8'b0000_0010,
      S_OPC   = 8'b0000_0100,
      S_IMM1  = 8'b0000_1000,
      S_IMM2  = 8'b0001_0000,
      S_LDW   = 8'b0010_0000,
      S_RDW   = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [15:0]          pc_ff, pc_in;
   logic [3:0]           flags_ff, flags_in;
   logic [7:0]           regs_ff [8];
   logic [7:0]           regs_in [8];
   logic [7:0]           op_ff, op_in;
   logic [7:0]           lo_ff, lo_in;
   logic [7:0]           rd_ff, rd_in;
   logic [2:0]           dest_ff, dest_in;

   logic [7:0]           mem [MEM_DEPTH];
   logic [7:0]           mem_q_ff;
   logic                 mem_we;
   logic [15:0]          mem_addr;
   logic [ADDR_BITS-1:0] mem_idx;
   logic [7:0]           mem_wdata;

   logic                 accept;
   logic [7:0]           op;
   logic [2:0]           dst, src, rsel;
   logic [7:0]           acc, opnd;
   logic                 cin;
   logic [15:0]          hl;
   logic [8:0]           sum9;
   logic [4:0]           hsum5;
   logic [7:0]           diff, incv, decv;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // opcode comes straight from memory in the decode cycle, else from the latch
   assign op    = (state_ff == S_OPC) ? mem_q_ff : op_ff;
   assign dst   = op[5:3];
   assign src   = op[2:0];
   assign rsel  = (op[7:6] == 2'b00) ? dst : src;
   assign acc   = regs_ff[REG_A];
   assign opnd  = regs_ff[rsel];
   assign cin   = flags_ff[0];
   assign hl    = {regs_ff[REG_H], regs_ff[REG_L]};
   assign sum9  = {1'b0, acc} + {1'b0, opnd};
   assign hsum5 = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]};
   assign diff  = acc - opnd;
   assign incv  = opnd + 8'd1;
   assign decv  = opnd - 8'd1;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_idx] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_idx];
   end

   assign mem_idx = (state_ff == S_CLEAR) ? clr_ff : mem_addr[ADDR_BITS-1:0];

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      regs_in   = regs_ff;
      op_in     = op_ff;
      lo_in     = lo_ff;
      rd_in     = rd_ff;
      dest_in   = dest_ff;
      mem_we    = 1'b0;
      mem_addr  = pc_ff;
      mem_wdata = acc;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = 8'h00;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rd_in    = 8'h00;
               mem_addr = req_item.address;
               state_in = S_RESP;
               priority case (req_item.req_type)
                  REQ_WRITE: begin
                     mem_we    = 1'b1;
                     mem_wdata = req_item.write_data;
                  end
                  REQ_READ: state_in = S_RDW;
                  REQ_EXEC: begin
                     mem_addr = pc_ff;
                     pc_in    = pc_ff + 16'd1;
                     state_in = S_OPC;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_RDW: begin
            rd_in    = mem_q_ff;
            state_in = S_RESP;
         end
         S_OPC: begin
            op_in    = op;
            dest_in  = REG_A;
            state_in = S_RESP;
            if (op[7:6] == 2'b01) begin
               if (op == OP_HALT) begin
                  state_in = S_RESP;
               end else if (src == REG_M) begin
                  mem_addr = hl;
                  dest_in  = dst;
                  state_in = S_LDW;
               end else if (dst == REG_M) begin
                  mem_addr  = hl;
                  mem_we    = 1'b1;
                  mem_wdata = opnd;
               end else begin
                  regs_in[dst] = opnd;
               end
            end else if (op[7:6] == 2'b10) begin
               if (src != REG_M) begin
                  unique case (dst)
                     ALU_ADD: begin
                        regs_in[REG_A] = sum9[7:0];
                        flags_in = {sum9[7:0] == 8'h00, 1'b0, hsum5[4], sum9[8]};
                     end
                     ALU_SUB, ALU_CP: begin
                        if (dst == ALU_SUB) begin
                           regs_in[REG_A] = diff;
                        end
                        flags_in = {diff == 8'h00, 1'b1, acc[3:0] < opnd[3:0], opnd > acc};
                     end
                     ALU_AND: begin
                        regs_in[REG_A] = acc & opnd;
                        flags_in = {(acc & opnd) == 8'h00, 1'b0, 1'b1, 1'b0};
                     end
                     ALU_XOR: begin
                        regs_in[REG_A] = acc ^ opnd;
                        flags_in = {(acc ^ opnd) == 8'h00, 3'b000};
                     end
                     ALU_OR: begin
                        regs_in[REG_A] = acc | opnd;
                        flags_in = {(acc | opnd) == 8'h00, 3'b000};
                     end
                     default: state_in = S_RESP;   // carry forms: no-op
                  endcase
               end
            end else if (op[7:6] == 2'b00 && src == REG_M) begin
               pc_in    = pc_ff + 16'd1;
               state_in = S_IMM1;
            end else if (op[7:6] == 2'b00 && (src == 3'd4 || src == 3'd5)) begin
               if (dst != REG_M) begin
                  if (src == 3'd4) begin
                     regs_in[dst] = incv;
                     flags_in = {incv == 8'h00, 1'b0, opnd[3:0] == 4'hF, cin};
                  end else begin
                     regs_in[dst] = decv;
                     flags_in = {decv == 8'h00, 1'b1, opnd[3:0] == 4'h0, cin};
                  end
               end
            end else begin
               priority case (op)
                  OP_LDABC: begin
                     mem_addr = {regs_ff[REG_B], regs_ff[REG_C]};
                     state_in = S_LDW;
                  end
                  OP_LDADE: begin
                     mem_addr = {regs_ff[REG_D], regs_ff[REG_E]};
                     state_in = S_LDW;
                  end
                  OP_LDAC: begin
                     mem_addr = {HIGH_PAGE, regs_ff[REG_C]};
                     state_in = S_LDW;
                  end
                  OP_LDBCA: begin
                     mem_addr = {regs_ff[REG_B], regs_ff[REG_C]};
                     mem_we   = 1'b1;
                  end
                  OP_LDDEA: begin
                     mem_addr = {regs_ff[REG_D], regs_ff[REG_E]};
                     mem_we   = 1'b1;
                  end
                  OP_LDCA: begin
                     mem_addr = {HIGH_PAGE, regs_ff[REG_C]};
                     mem_we   = 1'b1;
                  end
                  OP_LDHAN, OP_LDHNA, OP_LDANN, OP_LDNNA: begin
                     pc_in    = pc_ff + 16'd1;
                     state_in = S_IMM1;
                  end
                  OP_LDAHI, OP_LDAHD: begin
                     mem_addr = hl;
                     {regs_in[REG_H], regs_in[REG_L]} =
                        (op == OP_LDAHI) ? hl + 16'd1 : hl - 16'd1;
                     state_in = S_LDW;
                  end
                  OP_LDHIA, OP_LDHDA: begin
                     mem_addr = hl;
                     mem_we   = 1'b1;
                     {regs_in[REG_H], regs_in[REG_L]} =
                        (op == OP_LDHIA) ? hl + 16'd1 : hl - 16'd1;
                  end
                  OP_RLCA: begin
                     regs_in[REG_A] = {acc[6:0], acc[7]};
                     flags_in = {3'b000, acc[7]};
                  end
                  OP_RLA: begin
                     regs_in[REG_A] = {acc[6:0], cin};
                     flags_in = {3'b000, acc[7]};
                  end
                  OP_RRCA: begin
                     regs_in[REG_A] = {acc[0], acc[7:1]};
                     flags_in = {3'b000, acc[0]};
                  end
                  OP_RRA: begin
                     regs_in[REG_A] = {cin, acc[7:1]};
                     flags_in = {3'b000, acc[0]};
                  end
                  default: state_in = S_RESP;   // unknown opcode: no-op
               endcase
            end
         end
         S_IMM1: begin
            // mem_q_ff holds the first immediate byte
            state_in = S_RESP;
            if (op_ff[7:6] == 2'b00 && op_ff[2:0] == REG_M) begin
               if (op_ff[5:3] == REG_M) begin
                  mem_addr  = hl;
                  mem_we    = 1'b1;
                  mem_wdata = mem_q_ff;
               end else begin
                  regs_in[op_ff[5:3]] = mem_q_ff;
               end
            end else if (op_ff == OP_LDHAN) begin
               mem_addr = {HIGH_PAGE, mem_q_ff};
               state_in = S_LDW;
            end else if (op_ff == OP_LDHNA) begin
               mem_addr = {HIGH_PAGE, mem_q_ff};
               mem_we   = 1'b1;
            end else begin
               lo_in    = mem_q_ff;
               pc_in    = pc_ff + 16'd1;
               state_in = S_IMM2;
            end
         end
         S_IMM2: begin
            mem_addr = {mem_q_ff, lo_ff};
            if (op_ff == OP_LDANN) begin
               state_in = S_LDW;
            end else begin
               mem_we   = 1'b1;
               state_in = S_RESP;
            end
         end
         S_LDW: begin
            regs_in[dest_ff] = mem_q_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         pc_ff           <= 16'h0000;
         flags_ff        <= FLAGS_INIT;
         regs_ff[REG_B]  <= 8'h00;
         regs_ff[REG_C]  <= 8'h13;
         regs_ff[REG_D]  <= 8'h00;
         regs_ff[REG_E]  <= 8'hD8;
         regs_ff[REG_H]  <= 8'h01;
         regs_ff[REG_L]  <= 8'h4D;
         regs_ff[REG_M]  <= 8'h00;
         regs_ff[REG_A]  <= 8'h01;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pc_ff    <= pc_in;
         flags_ff <= flags_in;
         regs_ff  <= regs_in;
      end
      op_ff   <= op_in;
      lo_ff   <= lo_in;
      rd_ff   <= rd_in;
      dest_ff <= dest_in;
   end

   assign rsp_strobe         = (state_ff == S_RESP);
   assign rsp_item.read_data = rd_ff;
   assign rsp_item.acc_out   = regs_ff[REG_A];
   assign rsp_item.pair_bc   = {regs_ff[REG_B], regs_ff[REG_C]};
   assign rsp_item.pair_de   = {regs_ff[REG_D], regs_ff[REG_E]};
   assign rsp_item.pair_hl   = hl;
   assign rsp_item.pc_out    = pc_ff;
   assign rsp_item.flags_out = flags_ff;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("item accepted but core not busy");

   a_pc_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=> $stable(pc_ff))
      else $error("program counter moved while idle");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench of cpu_8bit_load_alu_core: directed and random memory writes, reads,
// unused request kinds and executed instructions, checked against a bit-true
// SystemVerilog model of the core. Depends on cpu8_pkg and the core RTL.
module tb;
   import cpu8_pkg::*;

   localparam int LIMIT = 1000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   cpu_8bit_load_alu_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // core model state
   logic [7:0]  regs_m [0:7];
   logic [3:0]  flags_m;
   logic [15:0] pc_m;
   logic [7:0]  mem_m [0:65535];

   rsp_item_type expected_rsp [$];
   int errors = 0;
   int cycles = 0;
   int sent = 0;
   int checked = 0;
   bit quiet = 1'b0;

   function automatic logic [7:0] fetch_byte();
      logic [7:0] v;
      v = mem_m[pc_m];
      pc_m = pc_m + 16'd1;
      return v;
   endfunction

   function automatic void run_alu(logic [2:0] grp, logic [7:0] r);
      logic [7:0] a;
      logic [8:0] s;
      a = regs_m[REG_A];
      case (grp)
         ALU_ADD: begin
            s = {1'b0, a} + {1'b0, r};
            flags_m = {s[7:0] == 8'd0, 1'b0, ({1'b0, a[3:0]} + {1'b0, r[3:0]}) > 5'h0F, s[8]};
            regs_m[REG_A] = s[7:0];
         end
         ALU_SUB, ALU_CP: begin
            s = {1'b0, a} - {1'b0, r};
            flags_m = {s[7:0] == 8'd0, 1'b1, a[3:0] < r[3:0], r > a};
            if (grp == ALU_SUB) regs_m[REG_A] = s[7:0];
         end
         ALU_AND: begin
            regs_m[REG_A] = a & r;
            flags_m = {(a & r) == 8'd0, 3'b010};
         end
         ALU_XOR: begin
            regs_m[REG_A] = a ^ r;
            flags_m = {(a ^ r) == 8'd0, 3'b000};
         end
         ALU_OR: begin
            regs_m[REG_A] = a | r;
            flags_m = {(a | r) == 8'd0, 3'b000};
         end
         default: ;
      endcase
   endfunction

   function automatic void run_instr();
      logic [7:0]  op, a, n, r, v;
      logic [2:0]  dst, src;
      logic        cin;
      logic [15:0] hl, t;
      op  = fetch_byte();
      dst = op[5:3];
      src = op[2:0];
      a   = regs_m[REG_A];
      cin = flags_m[0];
      hl  = {regs_m[REG_H], regs_m[REG_L]};
      if (op >= 8'h40 && op <= 8'h7F) begin
         if (op != OP_HALT) begin
            if (src == REG_M) regs_m[dst] = mem_m[hl];
            else if (dst == REG_M) mem_m[hl] = regs_m[src];
            else regs_m[dst] = regs_m[src];
         end
      end else if (op >= 8'h80 && op <= 8'hBF) begin
         if (src != REG_M) run_alu(dst, regs_m[src]);
      end else if (op < 8'h40 && src == REG_M) begin
         n = fetch_byte();
         if (dst == REG_M) mem_m[hl] = n;
         else regs_m[dst] = n;
      end else if (op < 8'h40 && (src == 3'd4 || src == 3'd5)) begin
         if (dst != REG_M) begin
            r = regs_m[dst];
            if (src == 3'd4) begin
               v = r + 8'd1;
               flags_m = {v == 8'd0, 1'b0, r[3:0] == 4'hF, cin};
            end else begin
               v = r - 8'd1;
               flags_m = {v == 8'd0, 1'b1, r[3:0] == 4'h0, cin};
            end
            regs_m[dst] = v;
         end
      end else begin
         case (op)
            OP_LDABC: regs_m[REG_A] = mem_m[{regs_m[REG_B], regs_m[REG_C]}];
            OP_LDADE: regs_m[REG_A] = mem_m[{regs_m[REG_D], regs_m[REG_E]}];
            OP_LDBCA: mem_m[{regs_m[REG_B], regs_m[REG_C]}] = a;
            OP_LDDEA: mem_m[{regs_m[REG_D], regs_m[REG_E]}] = a;
            OP_LDAC:  regs_m[REG_A] = mem_m[{HIGH_PAGE, regs_m[REG_C]}];
            OP_LDCA:  mem_m[{HIGH_PAGE, regs_m[REG_C]}] = a;
            OP_LDHAN: begin
               n = fetch_byte();
               regs_m[REG_A] = mem_m[{HIGH_PAGE, n}];
            end
            OP_LDHNA: begin
               n = fetch_byte();
               mem_m[{HIGH_PAGE, n}] = a;
            end
            OP_LDANN: begin
               t[7:0] = fetch_byte();
               t[15:8] = fetch_byte();
               regs_m[REG_A] = mem_m[t];
            end
            OP_LDNNA: begin
               t[7:0] = fetch_byte();
               t[15:8] = fetch_byte();
               mem_m[t] = a;
            end
            OP_LDAHI, OP_LDAHD, OP_LDHIA, OP_LDHDA: begin
               if (op == OP_LDAHI || op == OP_LDAHD) regs_m[REG_A] = mem_m[hl];
               else mem_m[hl] = a;
               t = (op == OP_LDAHI || op == OP_LDHIA) ? hl + 16'd1 : hl - 16'd1;
               {regs_m[REG_H], regs_m[REG_L]} = t;
            end
            OP_RLCA: begin
               regs_m[REG_A] = {a[6:0], a[7]};
               flags_m = {3'b000, a[7]};
            end
            OP_RLA: begin
               regs_m[REG_A] = {a[6:0], cin};
               flags_m = {3'b000, a[7]};
            end
            OP_RRCA: begin
               regs_m[REG_A] = {a[0], a[7:1]};
               flags_m = {3'b000, a[0]};
            end
            OP_RRA: begin
               regs_m[REG_A] = {cin, a[7:1]};
               flags_m = {3'b000, a[0]};
            end
            default: ;
         endcase
      end
   endfunction

   function automatic rsp_item_type predict_item(req_item_type it);
      rsp_item_type r;
      r = '0;
      case (it.req_type)
         REQ_WRITE: mem_m[it.address] = it.write_data;
         REQ_READ:  r.read_data = mem_m[it.address];
         REQ_EXEC:  run_instr();
         default: ;
      endcase
      r.acc_out   = regs_m[REG_A];
      r.pair_bc   = {regs_m[REG_B], regs_m[REG_C]};
      r.pair_de   = {regs_m[REG_D], regs_m[REG_E]};
      r.pair_hl   = {regs_m[REG_H], regs_m[REG_L]};
      r.pc_out    = pc_m;
      r.flags_out = flags_m;
      return r;
   endfunction

   // offer one item from a falling edge on and hold it until the core takes it
   task automatic send_item(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
      req_item_type it;
      it.req_type = kind;
      it.address = addr;
      it.write_data = data;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 7) begin
         start = 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      start = 1'b1;
      req_item = it;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(predict_item(it));
      sent++;
   endtask

   task automatic release_bus();
      @(negedge clock);
      start = 1'b0;
      req_item = {2'($urandom), 16'($urandom), 8'($urandom)};
   endtask

   // place an instruction at the program counter, then execute it
   task automatic exec_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
      send_item(REQ_WRITE, pc_m, op);
      send_item(REQ_WRITE, pc_m + 16'd1, b1);
      send_item(REQ_WRITE, pc_m + 16'd2, b2);
      send_item(REQ_EXEC, 16'($urandom), 8'($urandom));
   endtask

   task automatic wait_drained();
      release_bus();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            checked++;
            if (rsp_item.read_data !== e.read_data) begin
               $error("read_data expected %h actual %h", e.read_data, rsp_item.read_data);
               errors++;
            end
            if (rsp_item.acc_out !== e.acc_out) begin
               $error("acc_out expected %h actual %h", e.acc_out, rsp_item.acc_out);
               errors++;
            end
            if (rsp_item.pair_bc !== e.pair_bc) begin
               $error("pair_bc expected %h actual %h", e.pair_bc, rsp_item.pair_bc);
               errors++;
            end
            if (rsp_item.pair_de !== e.pair_de) begin
               $error("pair_de expected %h actual %h", e.pair_de, rsp_item.pair_de);
               errors++;
            end
            if (rsp_item.pair_hl !== e.pair_hl) begin
               $error("pair_hl expected %h actual %h", e.pair_hl, rsp_item.pair_hl);
               errors++;
            end
            if (rsp_item.pc_out !== e.pc_out) begin
               $error("pc_out expected %h actual %h", e.pc_out, rsp_item.pc_out);
               errors++;
            end
            if (rsp_item.flags_out !== e.flags_out) begin
               $error("flags_out expected %h actual %h", e.flags_out, rsp_item.flags_out);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic test_memory_extremes();
      send_item(REQ_WRITE, 16'h0000, 8'hFF);
      send_item(REQ_WRITE, 16'hFFFF, 8'h00);
      send_item(REQ_READ, 16'h0000, 8'hA5);
      send_item(REQ_READ, 16'hFFFF, 8'h5A);
      send_item(REQ_READ, 16'h8001, 8'hFF);
      send_item(2'd3, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_special_ops();
      exec_op(OP_HALT, 8'h00, 8'h00);
      exec_op(8'h3E, 8'h0F, 8'h00);        // LD A,0x0F
      exec_op(8'h3C, 8'h00, 8'h00);        // INC A: half-carry from 0xF
      exec_op(8'h05, 8'h00, 8'h00);        // DEC B from zero
      exec_op(8'h90, 8'h00, 8'h00);        // SUB B, operand above A
      exec_op(OP_RRA, 8'h00, 8'h00);       // carry rotates in
      exec_op(OP_LDHNA, 8'h80, 8'h00);
      exec_op(OP_LDHAN, 8'h80, 8'h00);
   endtask

   task automatic test_random_mix(int n);
      int k;
      logic [15:0] hl;
      for (k = 0; k < n; k++) begin
         quiet = (k >= n / 3 && k < n / 2);
         hl = {regs_m[REG_H], regs_m[REG_L]};
         case ($urandom_range(9))
            0: send_item(REQ_WRITE, ($urandom_range(1)) ? hl : {HIGH_PAGE, 8'($urandom)},
                         8'($urandom));
            1: send_item(REQ_READ, ($urandom_range(1)) ? 16'($urandom) : hl, 8'($urandom));
            2: send_item(($urandom_range(1)) ? 2'd3 : REQ_EXEC, 16'($urandom),
                         8'($urandom));
            default: exec_op(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         if (k == n / 4) wait_drained();
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < 65536; i++) mem_m[i] = 8'h00;
      for (i = 0; i < 8; i++) regs_m[i] = 8'h00;
      regs_m[REG_C] = 8'h13;
      regs_m[REG_E] = 8'hD8;
      regs_m[REG_H] = 8'h01;
      regs_m[REG_L] = 8'h4D;
      regs_m[REG_A] = 8'h01;
      flags_m = FLAGS_INIT;
      pc_m = 16'h0000;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_memory_extremes();
      test_special_ops();
      test_random_mix(340);
      wait_drained();
      repeat (20) @(posedge clock);
      $display("covered %0d items (writes, reads, unused requests, instructions)", sent);
      $display("%0d results checked, %0d mismatches", checked, errors);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
